@@ hw/rtl/calendar_date_difference_assert.svh @@
// Assertion macros shared by the calendar date difference RTL.
// Both expect a clock named clk in scope; CDD_ASSERT also expects a synchronous reset named rst.
`ifndef CALENDAR_DATE_DIFFERENCE_ASSERT_SVH
`define CALENDAR_DATE_DIFFERENCE_ASSERT_SVH

`ifndef ASSERT_OFF

// checked only outside reset
`define CDD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("calendar_date_difference: check failed");

// checked on every edge, reset included
`define CDD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("calendar_date_difference: check failed");

`else

`define CDD_ASSERT(lbl, prop)
`define CDD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ hw/rtl/cdd_pkg.sv @@
`default_nettype none

package cdd_pkg;

  localparam int unsigned MAX_YEAR = 9999;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;
  // day number width: 365 * (2**YEAR_W - 1) plus corrections fits in 23 bits
  localparam int NUM_W   = 23;

  // pipeline depth: three date stages plus the difference stage
  localparam int STAGES = 4;

  typedef logic signed [1:0] order_t;

  localparam order_t ORD_LATER   = 2'sb01;
  localparam order_t ORD_EARLIER = 2'sb11;
  localparam order_t ORD_SAME    = 2'sb00;

  typedef struct packed {
    logic [DAY_W-1:0]   day_a;
    logic [MONTH_W-1:0] month_a;
    logic [YEAR_W-1:0]  year_a;
    logic [DAY_W-1:0]   day_b;
    logic [MONTH_W-1:0] month_b;
    logic [YEAR_W-1:0]  year_b;
  } in_word_t;

  typedef struct packed {
    order_t             order;
    logic [COUNT_W-1:0] day_count;
    logic               valid_a;
    logic               valid_b;
  } out_word_t;

  // per-stage advance enables, bit k loads stage k+1
  typedef logic [STAGES-1:0] adv_t;

endpackage

`default_nettype wire

@@ hw/rtl/cdd_date_unit.sv @@
`default_nettype none

// Three-stage date checker and day-number generator for one date.
module cdd_date_unit
  import cdd_pkg::*;
(
  input  wire logic               clk,
  input  wire adv_t               adv,
  input  wire logic [DAY_W-1:0]   day,
  input  wire logic [MONTH_W-1:0] month,
  input  wire logic [YEAR_W-1:0]  year,
  output logic                    ok,
  output logic [NUM_W-1:0]        num
);

  // floor(p / 100) == (p * 5243) >> 19 for every 14-bit p
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = YEAR_W + 13;
  localparam int Q_W         = 8;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // stage 1: p = year - 1, p / 100, range checks
  logic [YEAR_W-1:0]  s1_p;
  logic [Q_W-1:0]     s1_q;
  logic [MONTH_W-1:0] s1_m;
  logic [DAY_W-1:0]   s1_d;
  logic               s1_ok;

  logic [YEAR_W-1:0]  p_next;
  logic [PROD_W-1:0]  prod;

  assign p_next = year - YEAR_W'(1);
  assign prod   = PROD_W'(p_next) * PROD_W'(RECIP_100);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_p  <= p_next;
      s1_q  <= Q_W'(prod >> RECIP_SHIFT);
      s1_m  <= month;
      s1_d  <= day;
      s1_ok <= (year != '0) && (32'(year) <= MAX_YEAR) &&
               (month >= 4'd1) && (month <= 4'd12) && (day != '0);
    end
  end

  // stage 2: leap rule, month length, year part of the day number
  logic [NUM_W-1:0]   s2_yr;
  logic [Q_W-1:0]     s2_q;
  logic [MONTH_W-1:0] s2_m;
  logic [DAY_W-1:0]   s2_d;
  logic               s2_leap;
  logic               s2_ok;

  logic [6:0]        rem;
  logic              cent;
  logic              leap_next;
  logic [YEAR_W-1:0] rem_full;

  assign rem_full  = s1_p - YEAR_W'(s1_q) * YEAR_W'(7'd100);
  assign rem       = rem_full[6:0];
  // year = p + 1 is a century year when p mod 100 is 99
  assign cent      = (rem == 7'd99);
  assign leap_next = ((s1_p[1:0] == 2'b11) && !cent) ||
                     (cent && (s1_q[1:0] == 2'b11));

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_yr   <= NUM_W'(s1_p) * NUM_W'(365) + NUM_W'(s1_p >> 2);
      s2_q    <= s1_q;
      s2_m    <= s1_m;
      s2_d    <= s1_d;
      s2_leap <= leap_next;
      s2_ok   <= s1_ok && (s1_d <= month_days(s1_m, leap_next));
    end
  end

  // stage 3: century corrections, month offset, day
  logic leap_bump;
  assign leap_bump = (s2_m > 4'd2) && s2_leap;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      num <= s2_yr - NUM_W'(s2_q) + NUM_W'(s2_q >> 2) + NUM_W'(days_before(s2_m))
             + NUM_W'(leap_bump) + NUM_W'(s2_d);
      ok  <= s2_ok;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cdd_diff.sv @@
`default_nettype none

// Output stage: absolute day difference, gated by both dates being valid.
module cdd_diff
  import cdd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic [NUM_W-1:0] num_a,
  input  wire logic [NUM_W-1:0] num_b,
  input  wire logic             ok_a,
  input  wire logic             ok_b,
  input  wire order_t           order,
  output out_word_t             word
);

  logic [NUM_W-1:0] span;

  assign span = (num_a >= num_b) ? (num_a - num_b) : (num_b - num_a);

  always_ff @(posedge clk) begin
    if (load) begin
      word.order     <= order;
      word.day_count <= (ok_a && ok_b) ? span[COUNT_W-1:0] : '0;
      word.valid_a   <= ok_a;
      word.valid_b   <= ok_b;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/calendar_date_difference.sv @@
`default_nettype none

// Gregorian date difference. Each input word holds two dates A and B; each
// result word reports whether each date is valid (year 1..9999, month 1..12,
// day within the month, Feb 29 only in leap years), the order of A against B
// (1 later, -1 earlier, 0 same, compared on the raw fields year, month, day),
// and the absolute number of days between them, forced to 0 when either date
// is invalid. Throughput is one word per clock while result_stall is low; an
// accepted input word reaches its result word through the four register stages:
// year split and divide-by-100, leap rule and year part of the day number,
// month and day offsets, and the final subtract. Stall on the result side
// propagates back only as far as needed: empty stages keep filling, so the
// input side stalls only when all four stages hold words.
module calendar_date_difference
  import cdd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      dates_valid,
  output logic           dates_stall,
  input  wire in_word_t  dates,
  output logic           result_valid,
  input  wire logic      result_stall,
  output out_word_t      result
);

`include "calendar_date_difference_assert.svh"

  // vld[k] marks that stage k+1 holds a word
  logic [STAGES-1:0] vld;
  adv_t              adv;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    adv[STAGES-1] = !vld[STAGES-1] || !result_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign dates_stall  = !adv[0];
  assign result_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= dates_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // order on the raw fields, year first
  order_t order_next;

  always_comb begin
    priority if (dates.year_a != dates.year_b) begin
      order_next = (dates.year_a > dates.year_b) ? ORD_LATER : ORD_EARLIER;
    end else if (dates.month_a != dates.month_b) begin
      order_next = (dates.month_a > dates.month_b) ? ORD_LATER : ORD_EARLIER;
    end else if (dates.day_a != dates.day_b) begin
      order_next = (dates.day_a > dates.day_b) ? ORD_LATER : ORD_EARLIER;
    end else begin
      order_next = ORD_SAME;
    end
  end

  // order rides alongside the three date stages
  order_t ord_s1;
  order_t ord_s2;
  order_t ord_s3;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ord_s1 <= order_next;
    end
    if (adv[1]) begin
      ord_s2 <= ord_s1;
    end
    if (adv[2]) begin
      ord_s3 <= ord_s2;
    end
  end

  logic             ok_a;
  logic             ok_b;
  logic [NUM_W-1:0] num_a;
  logic [NUM_W-1:0] num_b;

  cdd_date_unit u_date_a (
    .clk   (clk),
    .adv   (adv),
    .day   (dates.day_a),
    .month (dates.month_a),
    .year  (dates.year_a),
    .ok    (ok_a),
    .num   (num_a)
  );

  cdd_date_unit u_date_b (
    .clk   (clk),
    .adv   (adv),
    .day   (dates.day_b),
    .month (dates.month_b),
    .year  (dates.year_b),
    .ok    (ok_b),
    .num   (num_b)
  );

  cdd_diff u_diff (
    .clk   (clk),
    .load  (adv[STAGES-1]),
    .num_a (num_a),
    .num_b (num_b),
    .ok_a  (ok_a),
    .ok_b  (ok_b),
    .order (ord_s3),
    .word  (result)
  );

  // input side stalls only with every stage occupied
  `CDD_ASSERT(a_stall_full, dates_stall |-> (vld == '1))
  // an invalid date never yields a nonzero count
  `CDD_ASSERT(a_inv_a_zero, result_valid && !result.valid_a |-> result.day_count == '0)
  `CDD_ASSERT(a_inv_b_zero, result_valid && !result.valid_b |-> result.day_count == '0)
  // identical dates are zero days apart
  `CDD_ASSERT(a_same_zero, result_valid && (result.order == ORD_SAME) |-> result.day_count == '0)
  // reset empties the pipeline
  `CDD_ASSERT(a_rst_empty, $past(rst) |-> (vld == '0))

endmodule

`default_nettype wire
